@@ sv/lfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfp_pkg
// shared widths and constants of the range-sensor frame parser
// ----------------------------------------------------------------------------
package lfp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 16;
  localparam int unsigned TempW   = 14;
  localparam int unsigned StatusW = 2;

  // frame markers and classification thresholds
  localparam logic [ByteW-1:0]   START_BYTE         = 8'h59;
  localparam logic [WordW-1:0]   DIST_FAR           = 16'd65535;
  localparam logic [WordW-1:0]   STRENGTH_FAR_LIMIT = 16'd100;
  localparam logic [WordW-1:0]   DIST_CLOSE         = 16'd65534;
  localparam logic [WordW-1:0]   STRENGTH_CLOSE     = 16'd65535;
  localparam logic [WordW-1:0]   DIST_AMBIENT       = 16'd65532;
  localparam logic [TempW-1:0]   TEMP_OFFSET        = 14'd256;

  // status codes
  localparam logic [StatusW-1:0] STATUS_VALID    = 2'd0;
  localparam logic [StatusW-1:0] STATUS_TOO_FAR  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_SATURATE = 2'd2;
  localparam logic [StatusW-1:0] STATUS_CSUM_ERR = 2'd3;

endpackage

@@ sv/lfp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfp_if
// valid/ready channels of the frame parser: received bytes in, results out
// ----------------------------------------------------------------------------
interface lfp_byte_if;
  logic                      valid;
  logic                      ready;
  logic [lfp_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lfp_result_if;
  logic                               valid;
  logic                               ready;
  logic [lfp_pkg::WordW-1:0]          range_cm;
  logic [lfp_pkg::WordW-1:0]          signal_strength;
  logic signed [lfp_pkg::TempW-1:0]   chip_temp;
  logic [lfp_pkg::StatusW-1:0]        status;
  logic                               frame_done;

  modport source (output valid, output range_cm, output signal_strength,
                  output chip_temp, output status, output frame_done,
                  input ready);
  modport sink   (input valid, input range_cm, input signal_strength,
                  input chip_temp, input status, input frame_done,
                  output ready);
endinterface

@@ sv/lidar_frame_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_frame_parser
// byte-serial parser for nine-byte range-sensor frames with sum checksum
// ----------------------------------------------------------------------------
// usage
//   byte_i   : one received link byte per item (rx_byte)
//   result_o : one result item per accepted byte, carrying the currently
//              latched distance, strength, temperature and status, plus
//              frame_done on the checksum byte of a frame
//   frame    : 0x59 0x59 distL distH strL strH tempL tempH checksum
//   timing   : a byte's result is registered, shown the cycle after it is taken
//   rate     : one byte per cycle while not stalled; parser state, latches
//              and the result register all update in the accepting cycle
//   stall    : the latched values themselves form the result register; a
//              byte is taken while the result slot is empty or being drained
//              in the same cycle, so with result_o.ready held high bytes
//              stream through back to back
//   reset    : rst_ni low clears the parser to wait for a start byte, all
//              latched results to zero (status valid) and drops result_o.valid
// ----------------------------------------------------------------------------
module lidar_frame_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  lfp_byte_if.sink             byte_i,
  lfp_result_if.source         result_o
);

  typedef enum logic [2:0] {
    PH_WAIT_SOF,
    PH_DIST_L,
    PH_DIST_H,
    PH_STR_L,
    PH_STR_H,
    PH_TEMP_L,
    PH_TEMP_H,
    PH_CHECKSUM
  } phase_e;

  localparam int unsigned ByteW   = lfp_pkg::ByteW;
  localparam int unsigned WordW   = lfp_pkg::WordW;
  localparam int unsigned TempW   = lfp_pkg::TempW;
  localparam int unsigned StatusW = lfp_pkg::StatusW;

  // parser control
  phase_e               phase_q, phase_d;
  logic                 start_seen_q, start_seen_d;   // one lone start byte seen
  logic [ByteW-1:0]     sum_q, sum_d;

  // payload bytes still needed once their partner byte arrives
  logic [ByteW-1:0]     dist_lo_q, dist_hi_q, str_lo_q, temp_lo_q;

  // latched results, these drive the result channel directly
  logic [WordW-1:0]     dist_q, dist_d;
  logic [WordW-1:0]     str_q, str_d;
  logic [TempW-1:0]     temp_q, temp_d;
  logic [StatusW-1:0]   status_q, status_d;
  logic                 done_q, done_d;
  logic                 out_valid_q;

  logic                 accept;
  logic [ByteW-1:0]     b;
  logic [WordW-1:0]     str_word;
  logic [WordW-1:0]     temp_raw;
  logic [TempW-1:0]     temp_scaled;

  assign byte_i.ready = !out_valid_q || result_o.ready;
  assign accept       = byte_i.valid && byte_i.ready;
  assign b            = byte_i.rx_byte;

  // high byte arrives now, low byte was stored earlier
  assign str_word    = {b, str_lo_q};
  assign temp_raw    = {b, temp_lo_q};
  assign temp_scaled = {1'b0, temp_raw[WordW-1:3]} - lfp_pkg::TEMP_OFFSET;

  function automatic logic [StatusW-1:0] classify(input logic [WordW-1:0] range_val,
                                                   input logic [WordW-1:0] str);
    logic [StatusW-1:0] s;
    s = lfp_pkg::STATUS_VALID;
    if (range_val == lfp_pkg::DIST_FAR && str < lfp_pkg::STRENGTH_FAR_LIMIT) begin
      s = lfp_pkg::STATUS_TOO_FAR;
    end else if (range_val == lfp_pkg::DIST_CLOSE && str == lfp_pkg::STRENGTH_CLOSE) begin
      s = lfp_pkg::STATUS_SATURATE;
    end else if (range_val == lfp_pkg::DIST_AMBIENT) begin
      s = lfp_pkg::STATUS_SATURATE;
    end
    return s;
  endfunction

  // next-state logic for one accepted byte
  always_comb begin
    phase_d      = phase_q;
    start_seen_d = start_seen_q;
    sum_d        = sum_q;
    dist_d       = dist_q;
    str_d        = str_q;
    temp_d       = temp_q;
    status_d     = status_q;
    done_d       = 1'b0;
    unique case (phase_q)
      PH_WAIT_SOF: begin
        if (b == lfp_pkg::START_BYTE) begin
          if (start_seen_q) begin
            // second start byte opens the frame, both count into the sum
            start_seen_d = 1'b0;
            sum_d        = ByteW'(lfp_pkg::START_BYTE + lfp_pkg::START_BYTE);
            phase_d      = PH_DIST_L;
          end else begin
            start_seen_d = 1'b1;
          end
        end else begin
          // idle noise, also after a lone start byte: drop back to idle
          start_seen_d = 1'b0;
          sum_d        = '0;
        end
      end
      PH_CHECKSUM: begin
        if (sum_q != b) begin
          status_d = lfp_pkg::STATUS_CSUM_ERR;
        end
        done_d  = 1'b1;
        sum_d   = '0;
        phase_d = PH_WAIT_SOF;
      end
      default: begin
        // payload bytes, a 0x59 in here is plain data
        sum_d   = sum_q + b;
        phase_d = phase_e'(phase_q + 3'd1);
        if (phase_q == PH_STR_H) begin
          dist_d   = {dist_hi_q, dist_lo_q};
          str_d    = str_word;
          status_d = classify({dist_hi_q, dist_lo_q}, str_word);
        end else if (phase_q == PH_TEMP_H) begin
          temp_d = temp_scaled;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_WAIT_SOF;
      start_seen_q <= 1'b0;
      sum_q        <= '0;
      dist_q       <= '0;
      str_q        <= '0;
      temp_q       <= '0;
      status_q     <= lfp_pkg::STATUS_VALID;
      done_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        phase_q      <= phase_d;
        start_seen_q <= start_seen_d;
        sum_q        <= sum_d;
        dist_q       <= dist_d;
        str_q        <= str_d;
        temp_q       <= temp_d;
        status_q     <= status_d;
        done_q       <= done_d;
        out_valid_q  <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  // payload byte store, only read after being written in the same frame
  always_ff @(posedge clk_i) begin
    if (accept) begin
      case (phase_q)
        PH_DIST_L: dist_lo_q <= b;
        PH_DIST_H: dist_hi_q <= b;
        PH_STR_L:  str_lo_q  <= b;
        PH_TEMP_L: temp_lo_q <= b;
        default: ;
      endcase
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.range_cm        = dist_q;
  assign result_o.signal_strength = str_q;
  assign result_o.chip_temp       = $signed(temp_q);
  assign result_o.status          = status_q;
  assign result_o.frame_done      = done_q;

  // checksum byte always yields a frame-done result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && phase_q == PH_CHECKSUM |=> result_o.valid && result_o.frame_done)
    else $error("checksum byte did not flag frame done");

  // no other byte flags frame done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && phase_q != PH_CHECKSUM |=> !result_o.frame_done)
    else $error("frame done on a non-checksum byte");

  // two start bytes in a row open a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && phase_q == PH_WAIT_SOF && start_seen_q && b == lfp_pkg::START_BYTE
    |=> phase_q == PH_DIST_L)
    else $error("second start byte did not open a frame");

  // a shown frame-done result leaves the parser idle with a clear sum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.frame_done && !result_o.ready
    |-> phase_q == PH_WAIT_SOF && sum_q == '0)
    else $error("parser not idle after a completed frame");

  // a lone start flag only exists while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_seen_q |-> phase_q == PH_WAIT_SOF)
    else $error("start flag set inside a frame");

endmodule
